### sv/apsm_pkg.sv
// apsm_pkg: shared types and constants of the access policy state machine
// no dependencies
package apsm_pkg;

  localparam int CALL_ENTRIES = 16;
  localparam int DATA_ENTRIES = 16;
  localparam int STACK_DEPTH  = 16;
  localparam int STATE_BITS   = 8;
  localparam int ADDR_BITS    = 48;
  localparam int TAG_BITS     = 16;

  localparam int CIDX_BITS  = (CALL_ENTRIES > 1) ? $clog2(CALL_ENTRIES) : 1;
  localparam int DIDX_BITS  = (DATA_ENTRIES > 1) ? $clog2(DATA_ENTRIES) : 1;
  localparam int SIDX_BITS  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CCNT_BITS  = $clog2(CALL_ENTRIES + 1);
  localparam int DCNT_BITS  = $clog2(DATA_ENTRIES + 1);
  localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] EXEC_ACCESS = 3'd4;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_INSN  = 2'd1,
    KIND_LCALL = 2'd2,
    KIND_LDATA = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DENY     = 3'd0,
    ST_GRANT    = 3'd1,
    ST_SWITCH   = 3'd2,
    ST_RETURN   = 3'd3,
    ST_CALL     = 3'd4,
    ST_LOADOK   = 3'd5,
    ST_DUP      = 3'd6,
    ST_OVERFLOW = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DSCAN,
    S_STACK,
    S_CSCAN,
    S_LCALL,
    S_LDATA,
    S_DONE
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture input word
    logic dclr;       // clear data scan index
    logic dstep;      // examine one data entry
    logic cclr;       // clear call scan index
    logic cstep;      // examine one call entry
    logic stack_chk;  // compare top frame
    logic lcstep;     // call duplicate scan step
    logic ldstep;     // data duplicate scan step
    logic lc_write;   // commit call load
    logic ld_write;   // commit data load
    logic set_status; // write status from ctl
    status_t status;
  } apsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  slot_ok_c;
    logic  slot_ok_d;
    logic  d_done;    // data scan finished
    logic  d_hit;     // data rule decided (grant/switch, or deny of a data fault)
    logic  c_done;
    logic  c_hit;
    logic  s_hit;     // top frame matches
    logic  dup;       // duplicate seen
  } apsm_sts_t;

endpackage

### sv/apsm_if.sv
// apsm_if: valid/ready channel interfaces for input and result words
// depends on apsm_pkg
interface apsm_in_if import apsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [ADDR_BITS-1:0]  address;
  logic [TAG_BITS-1:0]   tag;
  logic [2:0]            access_mask;
  logic [ADDR_BITS-1:0]  return_address;
  logic [3:0]            slot;
  logic [7:0]            source_state;
  logic [7:0]            target_state;
  logic                  returns_allowed;
  modport source (output valid, kind, address, tag, access_mask, return_address, slot,
                  source_state, target_state, returns_allowed, input ready);
  modport sink (input valid, kind, address, tag, access_mask, return_address, slot,
                source_state, target_state, returns_allowed, output ready);
endinterface

interface apsm_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] current_state;
  logic [2:0] granted_mask;
  logic [4:0] stack_depth;
  modport source (output valid, status, current_state, granted_mask, stack_depth,
                  input ready);
  modport sink (input valid, status, current_state, granted_mask, stack_depth,
                output ready);
endinterface

### sv/apsm_ctrl.sv
// apsm_ctrl: controller state machine sequencing scans and loads
// depends on apsm_pkg
module apsm_ctrl import apsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  apsm_sts_t sts,
  output apsm_cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_DENY;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.dclr  = 1'b1;
          cmd.cclr  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = ST_DENY;
          state_nxt = S_DSCAN;
        end
      end
      S_DSCAN: begin
        priority if (sts.kind == KIND_LCALL) begin
          state_nxt = sts.slot_ok_c ? S_LCALL : S_DONE;
        end else if (sts.kind == KIND_LDATA) begin
          state_nxt = sts.slot_ok_d ? S_LDATA : S_DONE;
        end else if (sts.d_hit) begin
          state_nxt = S_DONE;
        end else if (sts.d_done) begin
          state_nxt = (sts.kind == KIND_INSN) ? S_STACK : S_DONE;
        end else begin
          cmd.dstep = 1'b1;
        end
      end
      S_STACK: begin
        cmd.stack_chk = 1'b1;
        state_nxt = sts.s_hit ? S_DONE : S_CSCAN;
      end
      S_CSCAN: begin
        if (sts.c_hit || sts.c_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.cstep = 1'b1;
        end
      end
      S_LCALL: begin
        if (sts.dup) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_DUP;
          state_nxt = S_DONE;
        end else if (sts.c_done) begin
          cmd.lc_write = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = ST_LOADOK;
          state_nxt = S_DONE;
        end else begin
          cmd.lcstep = 1'b1;
        end
      end
      S_LDATA: begin
        if (sts.dup) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_DUP;
          state_nxt = S_DONE;
        end else if (sts.d_done) begin
          cmd.ld_write = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status = ST_LOADOK;
          state_nxt = S_DONE;
        end else begin
          cmd.ldstep = 1'b1;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.lc_write && cmd.ld_write)) else $error("two table writes");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lc_write || cmd.ld_write) |=> out_valid) else $error("load not reported");

endmodule

### sv/apsm_dp.sv
// apsm_dp: tables, return stack, policy state and result register
// depends on apsm_pkg
module apsm_dp import apsm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_kind,
  input  logic [ADDR_BITS-1:0] in_address,
  input  logic [TAG_BITS-1:0]  in_tag,
  input  logic [2:0]           in_access_mask,
  input  logic [ADDR_BITS-1:0] in_return_address,
  input  logic [3:0]           in_slot,
  input  logic [7:0]           in_source_state,
  input  logic [7:0]           in_target_state,
  input  logic                 in_returns_allowed,
  input  apsm_cmd_t            cmd,
  output apsm_sts_t            sts,
  output logic [2:0]           out_status,
  output logic [7:0]           out_current_state,
  output logic [2:0]           out_granted_mask,
  output logic [4:0]           out_stack_depth
);

  // latched input word
  kind_t                 kind_r;
  logic [ADDR_BITS-1:0]  addr_r, raddr_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [2:0]            acc_r;
  logic [3:0]            slot_r;
  logic [STATE_BITS-1:0] src_r, tgt_r;
  logic                  rets_r;

  // tables
  logic [CALL_ENTRIES-1:0] cv_r;
  logic [ADDR_BITS-1:0]    ckey_r [CALL_ENTRIES];
  logic [STATE_BITS-1:0]   csrc_r [CALL_ENTRIES];
  logic [STATE_BITS-1:0]   ctgt_r [CALL_ENTRIES];
  logic                    cret_r [CALL_ENTRIES];
  logic [DATA_ENTRIES-1:0] dv_r;
  logic [STATE_BITS-1:0]   dsrc_r [DATA_ENTRIES];
  logic [STATE_BITS-1:0]   dtgt_r [DATA_ENTRIES];
  logic [TAG_BITS-1:0]     dtag_r [DATA_ENTRIES];
  logic [2:0]              dtyp_r [DATA_ENTRIES];
  logic [ADDR_BITS-1:0]    fra_r  [STACK_DEPTH];
  logic [STATE_BITS-1:0]   fsrc_r [STACK_DEPTH];

  logic [STATE_BITS-1:0] pstate_r;
  logic [DEPTH_BITS-1:0] fcnt_r;
  logic [DCNT_BITS-1:0]  di_r;
  logic [CCNT_BITS-1:0]  ci_r;
  logic                  dhit_r, chit_r, shit_r, dup_r;
  logic [2:0]            status_r, gmask_r;

  logic [DIDX_BITS-1:0] di;
  logic [CIDX_BITS-1:0] ci;
  logic [SIDX_BITS-1:0] top;
  logic [2:0]           eff_acc;
  logic                 d_match, c_match, slot_c, slot_d;
  logic [CIDX_BITS-1:0] ws_c;
  logic [DIDX_BITS-1:0] ws_d;

  assign di  = di_r[DIDX_BITS-1:0];
  assign ci  = ci_r[CIDX_BITS-1:0];
  assign top = SIDX_BITS'(fcnt_r - DEPTH_BITS'(1));
  assign eff_acc = (kind_r == KIND_INSN) ? EXEC_ACCESS : acc_r;
  assign d_match = dv_r[di] && dsrc_r[di] == pstate_r && dtag_r[di] == tag_r;
  assign c_match = cv_r[ci] && csrc_r[ci] == pstate_r && ckey_r[ci] == addr_r;
  assign slot_c  = 32'(slot_r) < CALL_ENTRIES;
  assign slot_d  = 32'(slot_r) < DATA_ENTRIES;
  assign ws_c    = CIDX_BITS'(slot_r);
  assign ws_d    = DIDX_BITS'(slot_r);

  always_comb begin
    sts.kind      = kind_r;
    sts.slot_ok_c = slot_c;
    sts.slot_ok_d = slot_d;
    sts.d_done    = di_r == DCNT_BITS'(DATA_ENTRIES);
    sts.d_hit     = dhit_r;
    sts.c_done    = ci_r == CCNT_BITS'(CALL_ENTRIES);
    sts.c_hit     = chit_r;
    sts.s_hit     = fcnt_r != '0 && fra_r[top] == addr_r;
    sts.dup       = dup_r;
  end

  // latched word: no reset
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= kind_t'(in_kind);
      addr_r  <= in_address;
      raddr_r <= in_return_address;
      tag_r   <= in_tag;
      acc_r   <= in_access_mask;
      slot_r  <= in_slot;
      src_r   <= STATE_BITS'(in_source_state);
      tgt_r   <= STATE_BITS'(in_target_state);
      rets_r  <= in_returns_allowed;
    end
  end

  // table payloads
  always_ff @(posedge clk) begin
    if (cmd.lc_write) begin
      ckey_r[ws_c] <= addr_r;
      csrc_r[ws_c] <= src_r;
      ctgt_r[ws_c] <= tgt_r;
      cret_r[ws_c] <= rets_r;
    end
    if (cmd.ld_write) begin
      dsrc_r[ws_d] <= src_r;
      dtgt_r[ws_d] <= tgt_r;
      dtag_r[ws_d] <= tag_r;
      dtyp_r[ws_d] <= acc_r;
    end
    if (cmd.cstep && c_match && cret_r[ci] && fcnt_r < DEPTH_BITS'(STACK_DEPTH)) begin
      fra_r[fcnt_r[SIDX_BITS-1:0]]  <= raddr_r;
      fsrc_r[fcnt_r[SIDX_BITS-1:0]] <= pstate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0; dv_r <= '0;
      pstate_r <= STATE_BITS'(1);
      fcnt_r <= '0;
      di_r <= '0; ci_r <= '0;
      dhit_r <= 1'b0; chit_r <= 1'b0; dup_r <= 1'b0;
      status_r <= ST_DENY; gmask_r <= '0;
    end else begin
      if (cmd.set_status) status_r <= cmd.status;
      if (cmd.latch) gmask_r <= '0;
      if (cmd.dclr) begin
        di_r <= '0; dhit_r <= 1'b0; dup_r <= 1'b0;
      end
      if (cmd.cclr) begin
        ci_r <= '0; chit_r <= 1'b0;
      end
      if (cmd.dstep) begin
        di_r <= di_r + DCNT_BITS'(1);
        if (d_match) begin
          if ((dtyp_r[di] & eff_acc) == '0) begin
            // an instruction fault still goes on to the stack and call table
            dhit_r   <= (kind_r != KIND_INSN);
            status_r <= ST_DENY;
          end else if (dtgt_r[di] == pstate_r) begin
            dhit_r   <= 1'b1;
            status_r <= ST_GRANT;
            gmask_r  <= dtyp_r[di];
          end else begin
            dhit_r   <= 1'b1;
            status_r <= ST_SWITCH;
            pstate_r <= dtgt_r[di];
          end
        end
      end
      if (cmd.stack_chk && sts.s_hit) begin
        fcnt_r   <= fcnt_r - DEPTH_BITS'(1);
        pstate_r <= fsrc_r[top];
        status_r <= ST_RETURN;
      end
      if (cmd.cstep) begin
        ci_r <= ci_r + CCNT_BITS'(1);
        if (c_match) begin
          chit_r   <= 1'b1;
          pstate_r <= ctgt_r[ci];
          if (cret_r[ci] && fcnt_r < DEPTH_BITS'(STACK_DEPTH)) begin
            fcnt_r   <= fcnt_r + DEPTH_BITS'(1);
            status_r <= ST_CALL;
          end else if (cret_r[ci]) begin
            status_r <= ST_OVERFLOW;
          end else begin
            status_r <= ST_CALL;
          end
        end
      end
      if (cmd.lcstep) begin
        ci_r <= ci_r + CCNT_BITS'(1);
        if (ci != ws_c && cv_r[ci] && csrc_r[ci] == src_r && ckey_r[ci] == addr_r)
          dup_r <= 1'b1;
      end
      if (cmd.ldstep) begin
        di_r <= di_r + DCNT_BITS'(1);
        if (di != ws_d && dv_r[di] && dsrc_r[di] == src_r && dtag_r[di] == tag_r)
          dup_r <= 1'b1;
      end
      if (cmd.lc_write) cv_r[ws_c] <= 1'b1;
      if (cmd.ld_write) dv_r[ws_d] <= 1'b1;
    end
  end

  assign out_status        = status_r;
  assign out_current_state = 8'(pstate_r);
  assign out_granted_mask  = gmask_r;
  assign out_stack_depth   = 5'(fcnt_r);

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= DEPTH_BITS'(STACK_DEPTH)) else $error("stack count overrun");
  a_grant_mask: assert property (@(posedge clk) disable iff (!rst_n)
    status_r != ST_GRANT |-> gmask_r == '0) else $error("mask without grant");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stack_chk && sts.s_hit |=> fcnt_r == $past(fcnt_r) - DEPTH_BITS'(1))
    else $error("pop miscounted");

endmodule

### sv/access_policy_state_machine.sv
// access_policy_state_machine: top level of the access policy engine
// depends on apsm_pkg, apsm_if, apsm_ctrl, apsm_dp
//
// usage
//   in  : one word per fault or table load (kind, address, tag, access mask,
//         return address, slot, source/target state, returns flag)
//   out : one result word per input word (status, current state, granted
//         mask, stack depth)
//   a word is taken when valid and ready are high at a rising edge
// timing
//   one word at a time; a data fault walks the data table one entry per
//   cycle until a rule decides it or the table ends
//   an instruction fault that the data table does not decide adds a stack
//   check and, unless the top frame matches, a call table walk
//   loads scan the target table for duplicate keys
// reset
//   policy state goes to 1, return stack empties, all table entries invalid
// stall
//   the result holds in the output register until taken; no new word is
//   accepted meanwhile
module access_policy_state_machine import apsm_pkg::*; (
  input logic clk,
  input logic rst_n,
  apsm_in_if.sink    in_ch,
  apsm_out_if.source out_ch
);

  apsm_cmd_t cmd;   // controller commands
  apsm_sts_t sts;   // datapath status

  // sequencer
  apsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, stack and result register
  apsm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_ch.kind),
    .in_address         (in_ch.address),
    .in_tag             (in_ch.tag),
    .in_access_mask     (in_ch.access_mask),
    .in_return_address  (in_ch.return_address),
    .in_slot            (in_ch.slot),
    .in_source_state    (in_ch.source_state),
    .in_target_state    (in_ch.target_state),
    .in_returns_allowed (in_ch.returns_allowed),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (out_ch.status),
    .out_current_state  (out_ch.current_state),
    .out_granted_mask   (out_ch.granted_mask),
    .out_stack_depth    (out_ch.stack_depth)
  );

endmodule

### tb/apsm_tb_scoreboard.sv
// apsm_tb_scoreboard: policy predictor and result checker for the access policy engine
// depends on apsm_pkg
package apsm_tb_scoreboard_pkg;
  import apsm_pkg::*;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] address;
    logic [TAG_BITS-1:0]  tag;
    logic [2:0]           access_mask;
    logic [ADDR_BITS-1:0] return_address;
    logic [3:0]           slot;
    logic [7:0]           source_state;
    logic [7:0]           target_state;
    logic                 returns_allowed;
  } fault_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] current_state;
    logic [2:0] granted_mask;
    logic [4:0] stack_depth;
  } verdict_t;

  class policy_scoreboard;
    logic [7:0]           cur_state;
    logic                 c_valid [CALL_ENTRIES];
    logic [ADDR_BITS-1:0] c_key [CALL_ENTRIES];
    logic [7:0]           c_src [CALL_ENTRIES];
    logic [7:0]           c_tgt [CALL_ENTRIES];
    logic                 c_ret [CALL_ENTRIES];
    logic                 d_valid [DATA_ENTRIES];
    logic [7:0]           d_src [DATA_ENTRIES];
    logic [7:0]           d_tgt [DATA_ENTRIES];
    logic [TAG_BITS-1:0]  d_tag [DATA_ENTRIES];
    logic [2:0]           d_types [DATA_ENTRIES];
    logic [ADDR_BITS-1:0] frame_ret [STACK_DEPTH];
    logic [7:0]           frame_src [STACK_DEPTH];
    int                   depth;
    verdict_t             pending_verdicts[$];
    int                   errors;

    function new();
      cur_state = 8'd1;
      depth = 0;
      errors = 0;
      for (int i = 0; i < CALL_ENTRIES; i++) c_valid[i] = 1'b0;
      for (int i = 0; i < DATA_ENTRIES; i++) d_valid[i] = 1'b0;
    endfunction

    // data rule shared by data and instruction faults
    function status_t data_rule(logic [TAG_BITS-1:0] tg, logic [2:0] acc,
                                output logic [2:0] granted);
      granted = 3'd0;
      for (int i = 0; i < DATA_ENTRIES; i++) begin
        if (d_valid[i] && d_src[i] == cur_state && d_tag[i] == tg) begin
          if ((d_types[i] & acc) == 3'd0) return ST_DENY;
          if (d_tgt[i] == cur_state) begin
            granted = d_types[i];
            return ST_GRANT;
          end
          cur_state = d_tgt[i];
          return ST_SWITCH;
        end
      end
      return ST_DENY;
    endfunction

    function void note_word(fault_word_t w);
      status_t st;
      logic [2:0] gr;
      verdict_t v;
      st = ST_DENY;
      gr = 3'd0;
      case (kind_t'(w.kind))
        KIND_DATA: st = data_rule(w.tag, w.access_mask, gr);
        KIND_INSN: begin
          st = data_rule(w.tag, EXEC_ACCESS, gr);
          if (st == ST_DENY) begin
            if (depth > 0 && frame_ret[depth-1] == w.address) begin
              depth--;
              cur_state = frame_src[depth];
              st = ST_RETURN;
            end else begin
              for (int i = 0; i < CALL_ENTRIES; i++) begin
                if (c_valid[i] && c_src[i] == cur_state && c_key[i] == w.address) begin
                  st = ST_CALL;
                  if (c_ret[i]) begin
                    if (depth < STACK_DEPTH) begin
                      frame_ret[depth] = w.return_address;
                      frame_src[depth] = cur_state;
                      depth++;
                    end else st = ST_OVERFLOW;
                  end
                  cur_state = c_tgt[i];
                  break;
                end
              end
            end
          end
        end
        KIND_LCALL: begin
          st = ST_LOADOK;
          for (int i = 0; i < CALL_ENTRIES; i++)
            if (i != w.slot && c_valid[i] && c_src[i] == w.source_state &&
                c_key[i] == w.address) st = ST_DUP;
          if (st == ST_LOADOK) begin
            c_valid[w.slot] = 1'b1;
            c_key[w.slot] = w.address;
            c_src[w.slot] = w.source_state;
            c_tgt[w.slot] = w.target_state;
            c_ret[w.slot] = w.returns_allowed;
          end
        end
        default: begin
          st = ST_LOADOK;
          for (int i = 0; i < DATA_ENTRIES; i++)
            if (i != w.slot && d_valid[i] && d_src[i] == w.source_state &&
                d_tag[i] == w.tag) st = ST_DUP;
          if (st == ST_LOADOK) begin
            d_valid[w.slot] = 1'b1;
            d_src[w.slot] = w.source_state;
            d_tgt[w.slot] = w.target_state;
            d_tag[w.slot] = w.tag;
            d_types[w.slot] = w.access_mask;
          end
        end
      endcase
      v.status = st;
      v.current_state = cur_state;
      v.granted_mask = gr;
      v.stack_depth = depth[4:0];
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t exp;
      if (pending_verdicts.size() == 0) begin
        $error("result word with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      exp = pending_verdicts.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.current_state !== exp.current_state) begin
        $error("current_state: expected %0d actual %0d", exp.current_state,
               got.current_state);
        errors++;
      end
      if (got.granted_mask !== exp.granted_mask) begin
        $error("granted_mask: expected %0d actual %0d", exp.granted_mask,
               got.granted_mask);
        errors++;
      end
      if (got.stack_depth !== exp.stack_depth) begin
        $error("stack_depth: expected %0d actual %0d", exp.stack_depth,
               got.stack_depth);
        errors++;
      end
    endfunction
  endclass
endpackage

### tb/tb_access_policy_state_machine.sv
// tb_access_policy_state_machine: directed and random fault/load traffic with checking
// depends on apsm_pkg, apsm_if, apsm_tb_scoreboard, access_policy_state_machine
module tb_access_policy_state_machine;
  timeunit 1ns;
  timeprecision 1ps;
  import apsm_pkg::*;
  import apsm_tb_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  apsm_in_if  in_ch ();
  apsm_out_if out_ch ();

  access_policy_state_machine u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  policy_scoreboard sb = new();
  int   cycles = 0;
  bit   calm = 1'b0;      // no idling on either side
  bit   hold_off = 1'b0;  // receiver long stall request
  bit   stim_done = 1'b0;

  // small pools so random faults actually hit loaded keys
  logic [ADDR_BITS-1:0] addr_pool [8];
  logic [TAG_BITS-1:0]  tag_pool [8];
  logic [ADDR_BITS-1:0] ret_pool [4];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.address = '0;
    in_ch.tag = '0;
    in_ch.access_mask = '0;
    in_ch.return_address = '0;
    in_ch.slot = '0;
    in_ch.source_state = '0;
    in_ch.target_state = '0;
    in_ch.returns_allowed = 1'b0;
    out_ch.ready = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      verdict_t got;
      got.status = status_t'(out_ch.status);
      got.current_state = out_ch.current_state;
      got.granted_mask = out_ch.granted_mask;
      got.stack_depth = out_ch.stack_depth;
      sb.check_verdict(got);
    end
  end

  // offer one word and wait until it is taken; random gaps before it
  task automatic send_word(fault_word_t w);
    while (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= w.kind;
    in_ch.address <= w.address;
    in_ch.tag <= w.tag;
    in_ch.access_mask <= w.access_mask;
    in_ch.return_address <= w.return_address;
    in_ch.slot <= w.slot;
    in_ch.source_state <= w.source_state;
    in_ch.target_state <= w.target_state;
    in_ch.returns_allowed <= w.returns_allowed;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(w);
  endtask

  function automatic fault_word_t mk(logic [1:0] k, logic [ADDR_BITS-1:0] a,
                                     logic [TAG_BITS-1:0] t, logic [2:0] acc,
                                     logic [ADDR_BITS-1:0] ra, logic [3:0] sl,
                                     logic [7:0] src, logic [7:0] tgt, logic r);
    fault_word_t w;
    w.kind = k; w.address = a; w.tag = t; w.access_mask = acc;
    w.return_address = ra; w.slot = sl; w.source_state = src;
    w.target_state = tgt; w.returns_allowed = r;
    return w;
  endfunction

  function automatic logic [ADDR_BITS-1:0] rnd_addr();
    return ADDR_BITS'({$urandom, $urandom});
  endfunction

  // random word, mostly built from pooled keys and a few states
  function automatic fault_word_t rnd_word();
    fault_word_t w;
    int sel;
    w.kind = 2'($urandom_range(3));
    w.address = ($urandom_range(9) < 8) ? addr_pool[$urandom_range(7)] : rnd_addr();
    if ($urandom_range(9) < 2) w.address = ret_pool[$urandom_range(3)];
    w.tag = ($urandom_range(9) < 8) ? tag_pool[$urandom_range(7)] : 16'($urandom);
    w.access_mask = 3'($urandom_range(7));
    w.return_address = ret_pool[$urandom_range(3)];
    if ($urandom_range(9) == 0) w.return_address = rnd_addr();
    w.slot = 4'($urandom_range(15));
    sel = int'($urandom_range(9));
    w.source_state = (sel < 8) ? 8'($urandom_range(4)) : 8'($urandom);
    w.source_state = (sel < 4) ? sb.cur_state : w.source_state;
    w.target_state = ($urandom_range(9) < 8) ? 8'($urandom_range(4)) : 8'($urandom);
    w.returns_allowed = 1'($urandom_range(1));
    // keep faults more frequent than loads
    if (w.kind[1] && $urandom_range(2) == 0) w.kind = 2'($urandom_range(1));
    return w;
  endfunction

  task automatic drain();
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  localparam logic [ADDR_BITS-1:0] AMAX = {ADDR_BITS{1'b1}};

  initial begin
    for (int i = 0; i < 8; i++) begin
      addr_pool[i] = rnd_addr();
      tag_pool[i] = 16'($urandom);
    end
    addr_pool[0] = '0; addr_pool[1] = AMAX;
    tag_pool[0] = '0; tag_pool[1] = 16'hffff;
    for (int i = 0; i < 4; i++) ret_pool[i] = rnd_addr();
    ret_pool[0] = AMAX;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-table faults, loads, grant, switch, deny on access,
    // duplicates, call with and without return, return
    send_word(mk(KIND_DATA, '0, '0, 3'd7, '0, 4'd0, 8'd0, 8'd0, 1'b0));
    send_word(mk(KIND_INSN, AMAX, 16'hffff, 3'd0, AMAX, 4'd15, 8'hff, 8'hff, 1'b1));
    send_word(mk(KIND_LDATA, '0, 16'hffff, 3'd3, '0, 4'd0, 8'd1, 8'd1, 1'b0));
    send_word(mk(KIND_DATA, '0, 16'hffff, 3'd4, '0, 4'd0, 8'd0, 8'd0, 1'b0));
    send_word(mk(KIND_DATA, '0, 16'hffff, 3'd2, '0, 4'd0, 8'd0, 8'd0, 1'b0));
    send_word(mk(KIND_LDATA, '0, 16'hffff, 3'd1, '0, 4'd5, 8'd1, 8'd2, 1'b0));
    send_word(mk(KIND_LDATA, '0, 16'h0000, 3'd4, '0, 4'd15, 8'd1, 8'd255, 1'b0));
    send_word(mk(KIND_INSN, '0, 16'h0000, 3'd0, '0, 4'd0, 8'd0, 8'd0, 1'b0));
    send_word(mk(KIND_LCALL, AMAX, '0, 3'd0, '0, 4'd15, 8'd255, 8'd3, 1'b1));
    send_word(mk(KIND_LCALL, AMAX, '0, 3'd0, '0, 4'd0, 8'd255, 8'd3, 1'b0));
    send_word(mk(KIND_LCALL, '0, '0, 3'd0, '0, 4'd0, 8'd3, 8'd255, 1'b0));
    send_word(mk(KIND_INSN, AMAX, 16'h1234, 3'd0, 48'h123456789abc, 4'd0, 8'd0,
                 8'd0, 1'b0));
    send_word(mk(KIND_INSN, '0, 16'h1234, 3'd0, '0, 4'd0, 8'd0, 8'd0, 1'b0));
    send_word(mk(KIND_INSN, 48'h123456789abc, 16'h1234, 3'd0, '0, 4'd0, 8'd0,
                 8'd0, 1'b0));
    // self loop call with return fills the stack to overflow
    send_word(mk(KIND_LCALL, 48'h5555, '0, 3'd0, '0, 4'd7, 8'd255, 8'd255, 1'b1));
    for (int i = 0; i < 17; i++)
      send_word(mk(KIND_INSN, 48'h5555, 16'h4321, 3'd0, 48'haaaa, 4'd0, 8'd0,
                   8'd0, 1'b0));
    send_word(mk(KIND_INSN, 48'haaaa, 16'h4321, 3'd0, '0, 4'd0, 8'd0, 8'd0, 1'b0));

    // random part: idling, then a calm stretch, then idling again with a long hold-off
    for (int n = 0; n < 1550; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 1000) begin
        // long receiver hold-off while words keep being offered
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      send_word(rnd_word());
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;
    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
